// File: rtl/inucl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Island nucleation step package
// Shared types, sizes and codes for the nucleation attempt block.
// ----------------------------------------------------------------------------
package inucl_pkg;

    localparam int MAX_GRAINS = 1024;
    localparam int IDX_W      = $clog2(MAX_GRAINS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int COPIES     = 9;
    localparam int DIV_STEPS  = 66;
    localparam int PIPE_DEPTH = 5;

    localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(MAX_GRAINS - COPIES);
    localparam logic [62:0]      SAT63      = {63{1'b1}};

    localparam logic [29:0] WIDTH_RESET  = 30'd6553600;
    localparam logic [29:0] HEIGHT_RESET = 30'd6553600;
    localparam logic [31:0] GROWTH_RESET = 32'd65536;

    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_GROWTH = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_NUCLEATED = 2'd0,
        ST_INSIDE    = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef struct packed {
        logic [16:0] time_draw;
        logic [15:0] x_draw;
        logic [15:0] y_draw;
    } in_word_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [62:0]      step_length;
        logic [62:0]      sim_time;
        logic [CNT_W-1:0] grain_total;
    } out_word_t;

    typedef struct packed {
        logic [62:0] birth;
        logic [31:0] xpos;
        logic [31:0] ypos;
    } grain_t;

    typedef struct packed {
        logic capture;
        logic div_start;
        logic time_upd;
        logic scan_clr;
        logic scan_run;
        logic decide;
        logic wr_en;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic scan_done;
        logic pipe_empty;
        logic nucleate;
        logic wr_last;
        logic out_busy;
    } sts_t;

endpackage
`default_nettype wire

// File: rtl/island_nucleation_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Island nucleation step
// One nucleation attempt per input word: time step, time update, coverage
// test against all stored grains and storage of nine periodic copies.
//
//   channel  direction  handshake              word
//   in       input      in_valid / in_ready    inucl_pkg::in_word_t
//   out      output     out_valid / out_ready  inucl_pkg::out_word_t
//   cfg      input      cfg_we                 cfg_index, cfg_data
//
// A word runs the bit-serial divider and waits for its done flag, reads the
// grain table once per stored grain, drains the coverage pipeline and, when
// the point is stored, writes its nine copies.
// Reset clears time and grain count and loads the default configuration;
// no clearing pass. A finished word waits while the output register is full
// and blocks the next input.
// ----------------------------------------------------------------------------
module island_nucleation_step (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [31:0]          cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire inucl_pkg::in_word_t  in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output inucl_pkg::out_word_t      out_data
);

    inucl_pkg::cmd_t cmd;
    inucl_pkg::sts_t sts;

    inucl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    inucl_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_word   (in_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_word  (out_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
`default_nettype wire

// File: rtl/inucl_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Time step divider
// Restoring divider, one quotient bit per cycle: floor(u*2^49/d), saturating.
// ----------------------------------------------------------------------------
module inucl_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [16:0] u,
    input  wire logic [59:0] d,
    output logic             done,
    output logic [62:0]      quot
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [16:0] ush_reg, ush_next;
    logic [59:0] rem_reg, rem_next;
    logic [62:0] q_reg, q_next;
    logic        sat_reg, sat_next;
    logic [60:0] rem_sh;
    logic [60:0] rem_sub;
    logic        qbit;

    assign rem_sh  = {rem_reg, ush_reg[16]};
    assign rem_sub = rem_sh - {1'b0, d};
    assign qbit    = (rem_sh >= {1'b0, d});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        ush_next  = ush_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        sat_next  = sat_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 7'(inucl_pkg::DIV_STEPS - 1);
            ush_next  = u;
            rem_next  = '0;
            q_next    = '0;
            sat_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            ush_next = {ush_reg[15:0], 1'b0};
            rem_next = qbit ? rem_sub[59:0] : rem_sh[59:0];
            q_next   = {q_reg[61:0], qbit};
            if (qbit && cnt_reg >= 7'd63)
            begin
                sat_next = 1'b1;
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        ush_reg <= ush_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        sat_reg <= sat_next;
    end

    assign done = done_reg;
    assign quot = sat_reg ? inucl_pkg::SAT63 : q_reg;

endmodule
`default_nettype wire

// File: rtl/inucl_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Nucleation controller
// Sequences capture, divide, time update, grain scan, store and result.
// ----------------------------------------------------------------------------
module inucl_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire inucl_pkg::sts_t  sts,
    output inucl_pkg::cmd_t       cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DSTART = 8'b0000_0010,
        S_DIV    = 8'b0000_0100,
        S_TIME   = 8'b0000_1000,
        S_SCAN   = 8'b0001_0000,
        S_DRAIN  = 8'b0010_0000,
        S_DECIDE = 8'b0100_0000,
        S_WRITE  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_pend_reg, out_pend_next;

    always_comb
    begin
        state_next    = state_reg;
        out_pend_next = out_pend_reg;
        cmd           = '0;
        in_ready      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = !out_pend_reg;
                if (out_pend_reg)
                begin
                    if (!sts.out_busy)
                    begin
                        cmd.load_out  = 1'b1;
                        out_pend_next = 1'b0;
                    end
                end
                else if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DSTART;
                end
            end
            S_DSTART:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_TIME;
                end
            end
            S_TIME:
            begin
                cmd.time_upd = 1'b1;
                cmd.scan_clr = 1'b1;
                state_next   = S_SCAN;
            end
            S_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    cmd.scan_run = 1'b1;
                end
            end
            S_DRAIN:
            begin
                if (sts.pipe_empty)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                if (sts.nucleate)
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    out_pend_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_WRITE:
            begin
                cmd.wr_en = 1'b1;
                if (sts.wr_last)
                begin
                    out_pend_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            out_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            out_pend_reg <= out_pend_next;
        end
    end

`ifndef SYNTHESIS
    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |-> state_reg == S_DIV)
        else $error("divider finished outside divide wait");
    a_pend_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_pend_reg |-> !in_ready)
        else $error("input taken while a result is pending");
    a_write_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.decide && sts.nucleate) |=> cmd.wr_en)
        else $error("store did not follow decision");
`endif

endmodule
`default_nettype wire

// File: rtl/inucl_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Nucleation datapath
// Configuration, time step, grain table, coverage pipeline and result word.
// ----------------------------------------------------------------------------
module inucl_dpath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [31:0]          cfg_data,
    input  wire inucl_pkg::in_word_t  in_word,
    input  wire logic                 out_ready,
    output logic                      out_valid,
    output inucl_pkg::out_word_t      out_word,
    input  wire inucl_pkg::cmd_t      cmd,
    output inucl_pkg::sts_t           sts
);

    localparam int IW = inucl_pkg::IDX_W;
    localparam int CW = inucl_pkg::CNT_W;

    logic [29:0] w_reg, h_reg;
    logic [31:0] g_reg;

    logic [16:0] u_reg;
    logic [59:0] area_reg;
    logic [59:0] area_next;
    logic [29:0] px_reg, py_reg;
    logic [45:0] xprod, yprod;

    logic        div_done;
    logic [62:0] step;

    logic [62:0] now_reg;
    logic [63:0] tsum;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] rd_idx_reg;
    logic        hit_reg;
    logic [1:0]  status_reg;
    logic        room;

    inucl_pkg::grain_t mem [inucl_pkg::MAX_GRAINS];
    inucl_pkg::grain_t rd_data_reg;
    inucl_pkg::grain_t wr_data;

    logic [inucl_pkg::PIPE_DEPTH-1:0] vld_reg;

    logic [62:0] age1_reg;
    logic [31:0] ax1_reg, ay1_reg;
    logic [62:0] age1;
    logic [33:0] dx1, dy1;

    logic [62:0] m1_reg;
    logic [63:0] m2_reg, sx_reg, sy_reg;
    logic [63:0] r3_reg, d3_reg;
    logic        big4_reg;
    logic [63:0] rr4_reg, d4_reg;

    logic [1:0]  wx_reg, wy_reg;
    logic [31:0] xoff, yoff;

    inucl_pkg::out_word_t out_reg;
    logic                 out_valid_reg;

    assign area_next = {30'b0, w_reg} * {30'b0, h_reg};
    assign xprod     = {30'b0, in_word.x_draw} * {16'b0, w_reg};
    assign yprod     = {30'b0, in_word.y_draw} * {16'b0, h_reg};

    inucl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .u     (u_reg),
        .d     (area_reg),
        .done  (div_done),
        .quot  (step)
    );

    assign tsum = {1'b0, now_reg} + {1'b0, step};
    assign room = (cnt_reg <= inucl_pkg::ROOM_LIMIT);

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= inucl_pkg::WIDTH_RESET;
            h_reg <= inucl_pkg::HEIGHT_RESET;
            g_reg <= inucl_pkg::GROWTH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                inucl_pkg::CFG_WIDTH:  w_reg <= cfg_data[29:0];
                inucl_pkg::CFG_HEIGHT: h_reg <= cfg_data[29:0];
                inucl_pkg::CFG_GROWTH: g_reg <= cfg_data;
                default:               ;
            endcase
        end
    end

    // capture word
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            u_reg    <= in_word.time_draw;
            area_reg <= area_next;
            px_reg   <= xprod[45:16];
            py_reg   <= yprod[45:16];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg       <= '0;
            cnt_reg       <= '0;
            rd_idx_reg    <= '0;
            hit_reg       <= 1'b0;
            vld_reg       <= '0;
            wx_reg        <= '0;
            wy_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= {vld_reg[inucl_pkg::PIPE_DEPTH-2:0], cmd.scan_run};
            if (cmd.time_upd)
            begin
                now_reg <= tsum[63] ? inucl_pkg::SAT63 : tsum[62:0];
            end
            if (cmd.scan_clr)
            begin
                rd_idx_reg <= '0;
                hit_reg    <= 1'b0;
                wx_reg     <= '0;
                wy_reg     <= '0;
            end
            else
            begin
                if (cmd.scan_run)
                begin
                    rd_idx_reg <= rd_idx_reg + CW'(1);
                end
                if (vld_reg[inucl_pkg::PIPE_DEPTH-1] && (big4_reg || d4_reg < rr4_reg))
                begin
                    hit_reg <= 1'b1;
                end
            end
            if (cmd.wr_en)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (wy_reg == 2'd2)
                begin
                    wy_reg <= '0;
                    wx_reg <= wx_reg + 2'd1;
                end
                else
                begin
                    wy_reg <= wy_reg + 2'd1;
                end
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // copy offsets: x outer (0, -w, +w), y inner (-h, 0, +h)
    always_comb
    begin
        unique case (wx_reg)
            2'd1:    xoff = -{2'b0, w_reg};
            2'd2:    xoff = {2'b0, w_reg};
            default: xoff = '0;
        endcase
        unique case (wy_reg)
            2'd0:    yoff = -{2'b0, h_reg};
            2'd2:    yoff = {2'b0, h_reg};
            default: yoff = '0;
        endcase
    end

    assign wr_data.birth = now_reg;
    assign wr_data.xpos  = {2'b0, px_reg} + xoff;
    assign wr_data.ypos  = {2'b0, py_reg} + yoff;

    // grain table
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cnt_reg[IW-1:0]] <= wr_data;
        end
        if (cmd.scan_run)
        begin
            rd_data_reg <= mem[rd_idx_reg[IW-1:0]];
        end
    end

    // coverage pipeline
    assign age1 = (now_reg >= rd_data_reg.birth) ? now_reg - rd_data_reg.birth : '0;
    assign dx1  = {{2{rd_data_reg.xpos[31]}}, rd_data_reg.xpos} - {4'b0, px_reg};
    assign dy1  = {{2{rd_data_reg.ypos[31]}}, rd_data_reg.ypos} - {4'b0, py_reg};

    always_ff @(posedge clk)
    begin
        age1_reg <= age1;
        ax1_reg  <= dx1[33] ? 32'(-dx1) : dx1[31:0];
        ay1_reg  <= dy1[33] ? 32'(-dy1) : dy1[31:0];

        m1_reg <= {31'b0, g_reg} * {32'b0, age1_reg[62:32]};
        m2_reg <= {32'b0, g_reg} * {32'b0, age1_reg[31:0]};
        sx_reg <= {32'b0, ax1_reg} * {32'b0, ax1_reg};
        sy_reg <= {32'b0, ay1_reg} * {32'b0, ay1_reg};

        r3_reg <= {1'b0, m1_reg} + {32'b0, m2_reg[63:32]};
        d3_reg <= sx_reg + sy_reg;

        big4_reg <= |r3_reg[63:32];
        rr4_reg  <= {32'b0, r3_reg[31:0]} * {32'b0, r3_reg[31:0]};
        d4_reg   <= d3_reg;
    end

    // decision and result word
    always_ff @(posedge clk)
    begin
        if (cmd.decide)
        begin
            if (hit_reg)
            begin
                status_reg <= inucl_pkg::ST_INSIDE;
            end
            else if (room)
            begin
                status_reg <= inucl_pkg::ST_NUCLEATED;
            end
            else
            begin
                status_reg <= inucl_pkg::ST_FULL;
            end
        end
        if (cmd.load_out)
        begin
            out_reg.status      <= status_reg;
            out_reg.step_length <= step;
            out_reg.sim_time    <= now_reg;
            out_reg.grain_total <= cnt_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    assign sts.div_done   = div_done;
    assign sts.scan_done  = (rd_idx_reg == cnt_reg);
    assign sts.pipe_empty = ~|vld_reg;
    assign sts.nucleate   = !hit_reg && room;
    assign sts.wr_last    = (wx_reg == 2'd2) && (wy_reg == 2'd2);
    assign sts.out_busy   = out_valid_reg && !out_ready;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(inucl_pkg::MAX_GRAINS))
        else $error("grain count beyond table size");
    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> cnt_reg < CW'(inucl_pkg::MAX_GRAINS))
        else $error("store into full table");
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before taken");
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_run |-> rd_idx_reg < cnt_reg)
        else $error("scan read beyond stored grains");
`endif

endmodule
`default_nettype wire
